FILE: design/dib_rgba_pkg.sv
// Package for the icon DIB pixel to RGBA converter.
// Holds the payload structs, depth codes and register indexes; depends on nothing.
package dib_rgba_pkg;

  // Configuration register indexes.
  localparam logic CFG_DEPTH_CODE   = 1'b0;
  localparam logic CFG_MASK_PRESENT = 1'b1;

  // Depth codes held in the depth register.
  localparam logic [2:0] DEPTH_1BPP  = 3'd0;
  localparam logic [2:0] DEPTH_4BPP  = 3'd1;
  localparam logic [2:0] DEPTH_8BPP  = 3'd2;
  localparam logic [2:0] DEPTH_24BPP = 3'd3;
  localparam logic [2:0] DEPTH_32BPP = 3'd4;

  // Input item modes.
  localparam logic MODE_PALETTE = 1'b0;
  localparam logic MODE_PIXEL   = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic        mode;
    logic        first_pixel;
    logic [7:0]  palette_index;
    logic [7:0]  palette_blue;
    logic [7:0]  palette_green;
    logic [7:0]  palette_red;
    logic [31:0] source_bytes;
    logic [2:0]  column_low;
    logic [7:0]  mask_byte;
  } in_payload_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       bad_depth;
  } out_payload_t;

endpackage

FILE: design/dib_icon_pixel_to_rgba_core.sv
// Top level of the icon DIB pixel to RGBA converter: palette memory, pixel
// pipeline and output register. Depends on dib_rgba_pkg.
//
//  Channel   | Ports                            | Moves per transfer
//  ----------+----------------------------------+--------------------------------
//  input     | in_valid, in_stall, in_data      | palette write or one pixel
//  result    | out_valid, out_stall, out_data   | one RGBA pixel (pixel items)
//  config    | cfg_we, cfg_index, cfg_wdata     | one register write
//
// One item is accepted per cycle while in_stall is low. A pixel's transfer
// loads the pipeline register and the registered palette read; when the output
// register is free, the color and alpha logic is loaded into it. Palette
// writes finish at their transfer and give no result. Reset is synchronous and
// active low; it sets depth to 32 bpp, marks the mask present and clears the
// seen-alpha flag. The palette is not cleared. A stall on the result side backs
// up through the pipeline register and reaches in_stall in the same cycle.
module dib_icon_pixel_to_rgba_core #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  dib_rgba_pkg::in_payload_t   in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output dib_rgba_pkg::out_payload_t  out_data,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [2:0]                  cfg_wdata
);
  import dib_rgba_pkg::*;

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  // Configuration registers.
  logic [2:0] depth_code_r;
  logic       mask_present_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_code_r   <= DEPTH_32BPP;
      mask_present_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEPTH_CODE:   depth_code_r   <= cfg_wdata;
        CFG_MASK_PRESENT: mask_present_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Handshake and pipeline control. The pipeline register holds pixels
  // only; a palette write is complete when it is transferred.
  logic s1_vld_r;
  logic out_valid_r;
  logic out_free;
  logic s1_move;
  logic in_xfer;
  logic pix_xfer;
  logic pal_xfer;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_vld_r && out_free;
  assign in_stall = s1_vld_r && !out_free;
  assign in_xfer  = in_valid && !in_stall;
  assign pix_xfer = in_xfer && (in_data.mode == MODE_PIXEL);
  assign pal_xfer = in_xfer && (in_data.mode == MODE_PALETTE);

  // Palette index for the indexed depths. Bit 7-column is the inverted
  // column; for 4 bpp even columns take the high nibble.
  logic [7:0] byte0;
  logic [7:0] rd_idx;
  logic       rd_oor;
  logic       wr_oor;

  assign byte0 = in_data.source_bytes[7:0];

  always_comb begin
    case (depth_code_r)
      DEPTH_1BPP: rd_idx = {7'd0, byte0[~in_data.column_low]};
      DEPTH_4BPP: rd_idx = in_data.column_low[0] ? {4'd0, byte0[3:0]} : {4'd0, byte0[7:4]};
      default:    rd_idx = byte0;
    endcase
  end

  assign rd_oor = {1'b0, rd_idx} >= 9'(PALETTE_DEPTH);
  assign wr_oor = {1'b0, in_data.palette_index} >= 9'(PALETTE_DEPTH);

  // Palette memory: one write port, one registered read port.
  logic [23:0] palette_mem [PALETTE_DEPTH];
  logic [23:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (pal_xfer && !wr_oor) begin
      palette_mem[in_data.palette_index[AW-1:0]] <=
        {in_data.palette_red, in_data.palette_green, in_data.palette_blue};
    end
    if (pix_xfer) begin
      rd_data_r <= palette_mem[rd_idx[AW-1:0]];
    end
  end

  // Pipeline register for pixel items.
  logic [31:0] s1_src_r;
  logic        s1_first_r;
  logic        s1_mbit_r;
  logic        s1_oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (pix_xfer) begin
      s1_vld_r <= 1'b1;
    end else if (s1_move) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_xfer) begin
      s1_src_r   <= in_data.source_bytes;
      s1_first_r <= in_data.first_pixel;
      s1_mbit_r  <= in_data.mask_byte[~in_data.column_low];
      s1_oor_r   <= rd_oor;
    end
  end

  // Color and alpha. The seen-alpha flag is updated in pixel order as each
  // pixel leaves the pipeline register.
  logic         seen_alpha_r;
  logic         seen_alpha_nxt;
  logic         seen_base;
  logic [23:0]  pal_rgb;
  out_payload_t res;

  assign seen_base = s1_first_r ? 1'b0 : seen_alpha_r;
  assign pal_rgb   = s1_oor_r ? 24'd0 : rd_data_r;

  always_comb begin
    res            = '0;
    seen_alpha_nxt = seen_base;
    case (depth_code_r)
      DEPTH_1BPP, DEPTH_4BPP, DEPTH_8BPP: begin
        res.red   = pal_rgb[23:16];
        res.green = pal_rgb[15:8];
        res.blue  = pal_rgb[7:0];
        res.alpha = ALPHA_OPAQUE;
      end
      DEPTH_24BPP: begin
        res.red   = s1_src_r[23:16];
        res.green = s1_src_r[15:8];
        res.blue  = s1_src_r[7:0];
        res.alpha = ALPHA_OPAQUE;
      end
      DEPTH_32BPP: begin
        res.red   = s1_src_r[23:16];
        res.green = s1_src_r[15:8];
        res.blue  = s1_src_r[7:0];
        res.alpha = s1_src_r[31:24];
        if (s1_src_r[31:24] != 8'd0) begin
          seen_alpha_nxt = 1'b1;
        end
      end
      default: begin
        res.bad_depth = 1'b1;
      end
    endcase
    // Mask applies only while no pixel of this image has carried alpha.
    if (!res.bad_depth && !seen_alpha_nxt && mask_present_r && s1_mbit_r) begin
      res.alpha = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_alpha_r <= 1'b0;
    end else if (s1_move) begin
      seen_alpha_r <= seen_alpha_nxt;
    end
  end

  // Output register.
  out_payload_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks on the pipeline control.
  a_stall_needs_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_vld_r)
    else $error("input stalled with an empty pipeline register");

  a_palette_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    pal_xfer |=> !s1_vld_r)
    else $error("palette write left a pixel in the pipeline register");

  a_pixel_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_valid_r)
    else $error("pixel lost between pipeline register and output");

  a_bad_depth_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.bad_depth) |->
      (out_data_r.red == 8'd0 && out_data_r.green == 8'd0 &&
       out_data_r.blue == 8'd0 && out_data_r.alpha == 8'd0))
    else $error("unsupported depth gave nonzero color");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!s1_vld_r && !out_valid_r && !seen_alpha_r))
    else $error("reset did not clear pipeline state");

endmodule
